// ===== design/utf8_to_ucs2_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder assertion macros
// Concurrent property checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_DEFINES_SVH
`define UTF8_TO_UCS2_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define U8U2_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define U8U2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define U8U2_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define U8U2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/u8u2_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder package
// Result record types and fixed constants of the decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [15:0] MAX_UNITS_RST = 16'd1024;
  localparam logic [30:0] ACC_SAT       = 31'h7FFF_FFFF;
  localparam logic [30:0] ACC_SHIFT_LIM = 31'h0200_0000;
  localparam logic [30:0] UNIT_BAD_MIN  = 31'h0000_FFFE;
  localparam logic [15:0] UNIT_REPL     = 16'hFFFD;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
    logic        truncated;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    res_t        res;
    logic        ended;
    logic [15:0] units;
  } emit_t;

endpackage

// ===== design/utf8_to_ucs2_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder
// Decodes zero-terminated UTF-8 byte strings into 16-bit code units.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one UTF-8 byte per transfer. A
// zero byte ends the string.
// Result channel: out_valid / out_stall carry one code unit per transfer,
// with end-of-string, truncation and last-of-run flags. A byte gives zero,
// one or two results; last_of_run marks the final one of that byte.
// Config: cfg_wr_en / cfg_wr_data write max_units (buffer length in units,
// terminator included). Write it only while the block is idle.
// Each result is written into the result queue when its byte transfers.
// Throughput: one byte per cycle unless in_stall; the decode is a single
// pass between the byte port and a four-entry result queue. A byte with two
// results takes two output transfers; result transfers bound sustained rate.
// in_stall rises when the result queue cannot hold two more results, so a
// stalled receiver stops input once three or four results are queued.
// Reset: clears decode state, empties the queue, sets max_units to 1024.
// ----------------------------------------------------------------------------
`include "utf8_to_ucs2_decoder_defines.svh"

module utf8_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_end_of_string,
  output logic        out_truncated,
  output logic        out_last_of_run,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] max_units_r;
  logic [30:0] acc_r, acc_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [15:0] units_r, units_nxt;
  logic        skip_r, skip_nxt;

  u8u2_pkg::res_t                     q_r [u8u2_pkg::QDEPTH];
  logic [u8u2_pkg::QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [u8u2_pkg::QCNT_W-1:0]        q_cnt_r;

  u8u2_pkg::res_t r0, r1;
  logic [1:0]     n_res;
  logic [15:0]    limit_m1;
  logic           in_acc, out_acc;

  function automatic u8u2_pkg::emit_t do_emit(input logic [30:0] value,
                                              input logic [15:0] units,
                                              input logic [15:0] lim_m1);
    u8u2_pkg::emit_t e;
    logic [15:0]     v;
    e = '0;
    v = (value >= u8u2_pkg::UNIT_BAD_MIN) ? u8u2_pkg::UNIT_REPL : value[15:0];
    if (v == 16'd0) begin
      e.res.end_of_string = 1'b1;
      e.ended             = 1'b1;
      e.units             = '0;
    end else if (units >= lim_m1) begin
      // buffer full: force the terminator
      e.res.end_of_string = 1'b1;
      e.res.truncated     = 1'b1;
      e.ended             = 1'b1;
      e.units             = '0;
    end else begin
      e.res.code_unit = v;
      e.units         = units + 16'd1;
    end
    return e;
  endfunction

  assign in_stall  = (q_cnt_r > u8u2_pkg::QCNT_W'(u8u2_pkg::QDEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;

  assign limit_m1 = (max_units_r == 16'd0) ? 16'd0 : max_units_r - 16'd1;

  always_comb begin
    u8u2_pkg::emit_t em;
    logic            do_lead;
    logic [30:0]     acc_sh;
    em        = '0;
    do_lead   = 1'b0;
    acc_sh    = '0;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    units_nxt = units_r;
    skip_nxt  = skip_r;
    r0        = '0;
    r1        = '0;
    n_res     = 2'd0;

    if (skip_r) begin
      if (in_byte == 8'h00) begin
        skip_nxt = 1'b0;
      end
    end else begin
      do_lead = 1'b1;
      if (pend_r != 3'd0) begin
        if (in_byte[7:6] == 2'b10) begin
          do_lead  = 1'b0;
          acc_sh   = (acc_r >= u8u2_pkg::ACC_SHIFT_LIM) ? u8u2_pkg::ACC_SAT
                                                        : {acc_r[24:0], in_byte[5:0]};
          acc_nxt  = acc_sh;
          pend_nxt = pend_r - 3'd1;
          if (pend_r == 3'd1) begin
            em        = do_emit(acc_sh, units_r, limit_m1);
            r0        = em.res;
            n_res     = 2'd1;
            units_nxt = em.units;
            acc_nxt   = '0;
            if (em.ended) begin
              skip_nxt = 1'b1;
            end
          end
        end else begin
          // cut the pending character short and emit it as it stands
          em        = do_emit(acc_r, units_r, limit_m1);
          r0        = em.res;
          n_res     = 2'd1;
          units_nxt = em.units;
          pend_nxt  = 3'd0;
          acc_nxt   = '0;
          if (em.ended) begin
            do_lead  = 1'b0;
            skip_nxt = (in_byte != 8'h00);
          end
        end
      end

      if (do_lead) begin
        case (in_byte) inside
          [8'h00:8'h7F]: begin
            em        = do_emit({23'd0, in_byte}, units_nxt, limit_m1);
            units_nxt = em.units;
            acc_nxt   = '0;
            if (n_res == 2'd0) begin
              r0 = em.res;
            end else begin
              r1 = em.res;
            end
            n_res = n_res + 2'd1;
            if (em.ended && in_byte != 8'h00) begin
              skip_nxt = 1'b1;
            end
          end
          [8'h80:8'hBF]: begin
            acc_nxt  = {25'd0, in_byte[5:0]};
            pend_nxt = 3'd5;
          end
          [8'hC0:8'hDF]: begin
            acc_nxt  = {26'd0, in_byte[4:0]};
            pend_nxt = 3'd1;
          end
          [8'hE0:8'hEF]: begin
            acc_nxt  = {27'd0, in_byte[3:0]};
            pend_nxt = 3'd2;
          end
          [8'hF0:8'hF7]: begin
            acc_nxt  = {28'd0, in_byte[2:0]};
            pend_nxt = 3'd3;
          end
          [8'hF8:8'hFB]: begin
            acc_nxt  = {29'd0, in_byte[1:0]};
            pend_nxt = 3'd4;
          end
          default: begin
            acc_nxt  = {30'd0, in_byte[0]};
            pend_nxt = 3'd5;
          end
        endcase
      end
    end

    if (n_res == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.last_of_run = 1'b1;
    end
  end

  // decode state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= u8u2_pkg::MAX_UNITS_RST;
      acc_r       <= '0;
      pend_r      <= '0;
      units_r     <= '0;
      skip_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_units_r <= cfg_wr_data;
      end
      if (in_acc) begin
        acc_r   <= acc_nxt;
        pend_r  <= pend_nxt;
        units_r <= units_nxt;
        skip_r  <= skip_nxt;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      q_r[wr_ptr_r] <= r0;
    end
    if (in_acc && n_res == 2'd2) begin
      q_r[wr_ptr_r + u8u2_pkg::QPTR_W'(1)] <= r1;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + u8u2_pkg::QPTR_W'(n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + u8u2_pkg::QPTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + (in_acc ? u8u2_pkg::QCNT_W'(n_res) : '0)
                         - (out_acc ? u8u2_pkg::QCNT_W'(1) : '0);
    end
  end

  assign out_code_unit     = q_r[rd_ptr_r].code_unit;
  assign out_end_of_string = q_r[rd_ptr_r].end_of_string;
  assign out_truncated     = q_r[rd_ptr_r].truncated;
  assign out_last_of_run   = q_r[rd_ptr_r].last_of_run;

  `U8U2_ASSERT_NOW(a_q_bound, clk, rst_n, 1'b1,
    q_cnt_r <= u8u2_pkg::QCNT_W'(u8u2_pkg::QDEPTH), "result queue overflow")
  `U8U2_ASSERT_NOW(a_skip_idle, clk, rst_n, skip_r,
    pend_r == 3'd0 && units_r == 16'd0, "skipping with a character in progress")
  `U8U2_ASSERT_NEXT(a_skip_hold, clk, rst_n, in_acc && skip_r && in_byte != 8'h00,
    skip_r, "skip ended on a nonzero byte")
  `U8U2_ASSERT_NEXT(a_drain, clk, rst_n, out_acc && !in_acc,
    q_cnt_r == $past(q_cnt_r) - u8u2_pkg::QCNT_W'(1), "queue count lost a transfer")

endmodule
